// ===== rtl/core/ps2hid_pkg.sv =====
// types, codes and usage tables of the ps/2 set 2 to hid translator
package ps2hid_pkg;

	localparam logic [7:0] CODE_E0 = 8'he0;
	localparam logic [7:0] CODE_E1 = 8'he1;
	localparam logic [7:0] CODE_F0 = 8'hf0;

	localparam logic [7:0] PLAIN_LAST      = 8'h83;
	localparam logic [7:0] EXT_LAST        = 8'h7d;
	localparam logic [7:0] PAUSE_LAST_BYTE = 8'h77;
	localparam logic [7:0] PAUSE_USAGE     = 8'h48;
	localparam logic [2:0] PAUSE_COUNT_END = 3'd7;

	localparam logic [7:0] MOD_LCTRL  = 8'h01;
	localparam logic [7:0] MOD_LSHIFT = 8'h02;
	localparam logic [7:0] MOD_LALT   = 8'h04;
	localparam logic [7:0] MOD_LGUI   = 8'h08;
	localparam logic [7:0] MOD_RCTRL  = 8'h10;
	localparam logic [7:0] MOD_RSHIFT = 8'h20;
	localparam logic [7:0] MOD_RALT   = 8'h40;
	localparam logic [7:0] MOD_RGUI   = 8'h80;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_E0   = 2'd1,
		MODE_E1   = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic       rel;
		logic       ext_rel;
		logic [2:0] pause_cnt;
		logic [7:0] mods;
	} xlat_state_t;

	localparam logic [7:0] PLAIN_USAGE [0:131] = '{
		8'h00,8'h42,8'h00,8'h3e,8'h3c,8'h3a,8'h3b,8'h45,
		8'h00,8'h43,8'h41,8'h3f,8'h3d,8'h2b,8'h35,8'h00,
		8'h00,8'he2,8'he1,8'h00,8'he0,8'h14,8'h1e,8'h00,
		8'h00,8'h00,8'h1d,8'h16,8'h04,8'h1a,8'h1f,8'h00,
		8'h00,8'h06,8'h1b,8'h07,8'h08,8'h21,8'h20,8'h00,
		8'h00,8'h2c,8'h19,8'h09,8'h17,8'h15,8'h22,8'h00,
		8'h00,8'h11,8'h05,8'h0b,8'h0a,8'h1c,8'h23,8'h00,
		8'h00,8'h00,8'h10,8'h0d,8'h18,8'h24,8'h25,8'h00,
		8'h00,8'h36,8'h0e,8'h0c,8'h12,8'h27,8'h26,8'h00,
		8'h00,8'h37,8'h38,8'h0f,8'h33,8'h13,8'h2d,8'h00,
		8'h00,8'h00,8'h34,8'h00,8'h2f,8'h2e,8'h00,8'h00,
		8'h39,8'he5,8'h28,8'h30,8'h00,8'h31,8'h00,8'h00,
		8'h00,8'h64,8'h00,8'h00,8'h00,8'h00,8'h2a,8'h00,
		8'h00,8'h59,8'h00,8'h5c,8'h5f,8'h00,8'h00,8'h00,
		8'h62,8'h63,8'h5a,8'h5d,8'h5e,8'h60,8'h29,8'h53,
		8'h44,8'h57,8'h5b,8'h56,8'h55,8'h61,8'h47,8'h00,
		8'h00,8'h00,8'h00,8'h40
	};

	function automatic logic [7:0] ext_usage(input logic [6:0] code);
		logic [7:0] u;
		case (code)
			7'h11: u = 8'he6;
			7'h14: u = 8'he4;
			7'h1f: u = 8'he3;
			7'h27: u = 8'he7;
			7'h2f: u = 8'h76;
			7'h4a: u = 8'h54;
			7'h5a: u = 8'h58;
			7'h69: u = 8'h4d;
			7'h6b: u = 8'h50;
			7'h6c: u = 8'h4a;
			7'h70: u = 8'h49;
			7'h71: u = 8'h4c;
			7'h72: u = 8'h51;
			7'h74: u = 8'h4f;
			7'h75: u = 8'h52;
			7'h7a: u = 8'h4e;
			7'h7c: u = 8'h46;
			7'h7d: u = 8'h4b;
			default: u = 8'h00;
		endcase
		return u;
	endfunction

	function automatic logic [7:0] plain_mod_bit(input logic [7:0] code);
		logic [7:0] m;
		case (code)
			8'h11: m = MOD_LALT;
			8'h12: m = MOD_LSHIFT;
			8'h14: m = MOD_LCTRL;
			8'h59: m = MOD_RSHIFT;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] ext_mod_bit(input logic [7:0] code);
		logic [7:0] m;
		case (code)
			8'h11: m = MOD_RALT;
			8'h14: m = MOD_RCTRL;
			8'h1f: m = MOD_LGUI;
			8'h27: m = MOD_RGUI;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/core/ps2hid_decode.sv =====
// next-state and usage lookup for one received scan code byte
module ps2hid_decode (
	input  logic                     [7:0] code,
	input  ps2hid_pkg::xlat_state_t        cur,
	output ps2hid_pkg::xlat_state_t        nxt,
	output logic                     [7:0] key
);

	logic [2:0] cnt_inc;

	assign cnt_inc = 3'(cur.pause_cnt + 3'd1);

	always_comb begin
		nxt = cur;
		key = 8'h00;
		case (cur.mode)
			ps2hid_pkg::MODE_E1: begin
				nxt.pause_cnt = cnt_inc;
				if (cnt_inc == ps2hid_pkg::PAUSE_COUNT_END) begin
					if (code == ps2hid_pkg::PAUSE_LAST_BYTE)
						key = ps2hid_pkg::PAUSE_USAGE;
					nxt.pause_cnt = 3'd0;
					nxt.mode      = ps2hid_pkg::MODE_IDLE;
				end
			end
			ps2hid_pkg::MODE_E0: begin
				if (code == ps2hid_pkg::CODE_F0) begin
					nxt.ext_rel = 1'b1;
				end else if (cur.ext_rel) begin
					nxt.mods    = cur.mods & ~ps2hid_pkg::ext_mod_bit(code);
					nxt.ext_rel = 1'b0;
					nxt.mode    = ps2hid_pkg::MODE_IDLE;
				end else begin
					nxt.mode = ps2hid_pkg::MODE_IDLE;
					if (code <= ps2hid_pkg::EXT_LAST) begin
						nxt.mods = cur.mods | ps2hid_pkg::ext_mod_bit(code);
						key      = ps2hid_pkg::ext_usage(code[6:0]);
					end
				end
			end
			default: begin
				// idle, and the unused mode code
				if (code == ps2hid_pkg::CODE_E1) begin
					nxt.mode = ps2hid_pkg::MODE_E1;
				end else if (code == ps2hid_pkg::CODE_E0) begin
					nxt.mode = ps2hid_pkg::MODE_E0;
				end else if (code == ps2hid_pkg::CODE_F0) begin
					nxt.rel = 1'b1;
				end else if (cur.rel) begin
					nxt.rel  = 1'b0;
					nxt.mods = cur.mods & ~ps2hid_pkg::plain_mod_bit(code);
				end else if (code <= ps2hid_pkg::PLAIN_LAST) begin
					nxt.mods = cur.mods | ps2hid_pkg::plain_mod_bit(code);
					key      = ps2hid_pkg::PLAIN_USAGE[code];
				end
			end
		endcase
	end

endmodule

// ===== rtl/core/ps2_scancode_to_hid_translator_unit.sv =====
// ps/2 scan code set 2 to usb hid usage translator, top level
//
// input channel: scan_valid / scan_stall with scan_code, one keyboard byte per item.
// output channel: key_valid / key_stall with usb_key and modifier_byte, exactly one
// item for every byte taken in. usb_key is 0 for prefixes, breaks, unknown codes and
// pause bytes other than the closing 77; modifier_byte is the held modifier set after that byte.
// a byte taken in passes through the input register and then the result register,
// where it shows on the outputs.
// throughput: one byte per cycle unless key_stall holds the result register, set by the
// single decode step between the two registers; the prefix and modifier state updates in that same step.
// when key_stall is high while key_valid is high the result register holds and the input register keeps
// its byte; scan_stall rises only while the input register is full and cannot move.
// reset clears both valid flags, the prefix tracking, the pause counter and the
// held modifiers; the block takes a byte in the first cycle after reset.
module ps2_scancode_to_hid_translator_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_stall,
	input  logic [7:0] scan_code,
	output logic       key_valid,
	input  logic       key_stall,
	output logic [7:0] usb_key,
	output logic [7:0] modifier_byte
);

	logic                    valid_s1;
	logic [7:0]              code_s1;
	logic                    advance;
	ps2hid_pkg::xlat_state_t st_q;
	ps2hid_pkg::xlat_state_t st_nxt;
	logic [7:0]              key_nxt;

	assign advance    = !key_valid || !key_stall;
	assign scan_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!scan_stall) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!scan_stall && scan_valid)
			code_s1 <= scan_code;
	end

	ps2hid_decode u_decode (
		.code (code_s1),
		.cur  (st_q),
		.nxt  (st_nxt),
		.key  (key_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= '{mode: ps2hid_pkg::MODE_IDLE, rel: 1'b0, ext_rel: 1'b0,
				pause_cnt: 3'd0, mods: 8'h00};
			key_valid <= 1'b0;
		end else if (advance) begin
			key_valid <= valid_s1;
			if (valid_s1)
				st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			usb_key       <= key_nxt;
			modifier_byte <= st_nxt.mods;
		end
	end

	// a byte moving out of the input register always lands in the result register
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> key_valid)
		else $error("decoded item lost");

	// translator state only changes when an item is decoded
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(st_q))
		else $error("state changed without an item");

	a_pause_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode != ps2hid_pkg::MODE_E1) |-> (st_q.pause_cnt == 3'd0))
		else $error("pause counter running outside e1 sequence");

	a_ext_rel_mode: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.ext_rel |-> (st_q.mode == ps2hid_pkg::MODE_E0))
		else $error("extended release flag outside e0 mode");

	// while key_valid is high the output register shows the held modifier set
	a_mods_match: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid |-> (modifier_byte == st_q.mods))
		else $error("modifier byte out of step with held modifiers");

endmodule

// ===== tb/hid_report_checker.sv =====
// checker for the scan code translator: predicts each hid report and compares it
`timescale 1ns / 100ps

module hid_report_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	input  logic       scan_stall,
	input  logic [7:0] scan_code,
	input  logic       key_valid,
	input  logic       key_stall,
	input  logic [7:0] usb_key,
	input  logic [7:0] modifier_byte,
	output int         fail_count,
	output int         outstanding
);

	typedef struct packed {
		logic [7:0] key;
		logic [7:0] mods;
	} hid_report_t;

	// usage of each plain set 2 code up to the last table entry
	localparam logic [7:0] PLAIN_KEY_TBL [0:131] = '{
		8'h00,8'h42,8'h00,8'h3e,8'h3c,8'h3a,8'h3b,8'h45,
		8'h00,8'h43,8'h41,8'h3f,8'h3d,8'h2b,8'h35,8'h00,
		8'h00,8'he2,8'he1,8'h00,8'he0,8'h14,8'h1e,8'h00,
		8'h00,8'h00,8'h1d,8'h16,8'h04,8'h1a,8'h1f,8'h00,
		8'h00,8'h06,8'h1b,8'h07,8'h08,8'h21,8'h20,8'h00,
		8'h00,8'h2c,8'h19,8'h09,8'h17,8'h15,8'h22,8'h00,
		8'h00,8'h11,8'h05,8'h0b,8'h0a,8'h1c,8'h23,8'h00,
		8'h00,8'h00,8'h10,8'h0d,8'h18,8'h24,8'h25,8'h00,
		8'h00,8'h36,8'h0e,8'h0c,8'h12,8'h27,8'h26,8'h00,
		8'h00,8'h37,8'h38,8'h0f,8'h33,8'h13,8'h2d,8'h00,
		8'h00,8'h00,8'h34,8'h00,8'h2f,8'h2e,8'h00,8'h00,
		8'h39,8'he5,8'h28,8'h30,8'h00,8'h31,8'h00,8'h00,
		8'h00,8'h64,8'h00,8'h00,8'h00,8'h00,8'h2a,8'h00,
		8'h00,8'h59,8'h00,8'h5c,8'h5f,8'h00,8'h00,8'h00,
		8'h62,8'h63,8'h5a,8'h5d,8'h5e,8'h60,8'h29,8'h53,
		8'h44,8'h57,8'h5b,8'h56,8'h55,8'h61,8'h47,8'h00,
		8'h00,8'h00,8'h00,8'h40
	};

	ps2hid_pkg::mode_t prefix = ps2hid_pkg::MODE_IDLE;
	logic              brk_plain = 1'b0;
	logic              brk_ext = 1'b0;
	logic [2:0]        pause_seen = 3'd0;
	logic [7:0]        held = 8'h00;
	int                errs = 0;
	hid_report_t       awaited_reports [$];

	function automatic logic [7:0] ext_key_of(input logic [7:0] code);
		case (code)
			8'h11: return 8'he6;
			8'h14: return 8'he4;
			8'h1f: return 8'he3;
			8'h27: return 8'he7;
			8'h2f: return 8'h76;
			8'h4a: return 8'h54;
			8'h5a: return 8'h58;
			8'h69: return 8'h4d;
			8'h6b: return 8'h50;
			8'h6c: return 8'h4a;
			8'h70: return 8'h49;
			8'h71: return 8'h4c;
			8'h72: return 8'h51;
			8'h74: return 8'h4f;
			8'h75: return 8'h52;
			8'h7a: return 8'h4e;
			8'h7c: return 8'h46;
			8'h7d: return 8'h4b;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] plain_mod_of(input logic [7:0] code);
		case (code)
			8'h11: return ps2hid_pkg::MOD_LALT;
			8'h12: return ps2hid_pkg::MOD_LSHIFT;
			8'h14: return ps2hid_pkg::MOD_LCTRL;
			8'h59: return ps2hid_pkg::MOD_RSHIFT;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] ext_mod_of(input logic [7:0] code);
		case (code)
			8'h11: return ps2hid_pkg::MOD_RALT;
			8'h14: return ps2hid_pkg::MOD_RCTRL;
			8'h1f: return ps2hid_pkg::MOD_LGUI;
			8'h27: return ps2hid_pkg::MOD_RGUI;
			default: return 8'h00;
		endcase
	endfunction

	// advances the prefix and modifier tracking by one byte
	function hid_report_t translate_byte(input logic [7:0] code);
		hid_report_t r;
		r.key = 8'h00;
		case (prefix)
			ps2hid_pkg::MODE_E1: begin
				pause_seen = pause_seen + 3'd1;
				if (pause_seen == ps2hid_pkg::PAUSE_COUNT_END) begin
					if (code == ps2hid_pkg::PAUSE_LAST_BYTE)
						r.key = ps2hid_pkg::PAUSE_USAGE;
					pause_seen = 3'd0;
					prefix = ps2hid_pkg::MODE_IDLE;
				end
			end
			ps2hid_pkg::MODE_E0: begin
				if (code == ps2hid_pkg::CODE_F0) begin
					brk_ext = 1'b1;
				end else if (brk_ext) begin
					held = held & ~ext_mod_of(code);
					brk_ext = 1'b0;
					prefix = ps2hid_pkg::MODE_IDLE;
				end else begin
					prefix = ps2hid_pkg::MODE_IDLE;
					if (code <= ps2hid_pkg::EXT_LAST) begin
						held = held | ext_mod_of(code);
						r.key = ext_key_of(code);
					end
				end
			end
			default: begin
				// a pending plain break survives the e0 and e1 prefixes
				if (code == ps2hid_pkg::CODE_E1) begin
					prefix = ps2hid_pkg::MODE_E1;
				end else if (code == ps2hid_pkg::CODE_E0) begin
					prefix = ps2hid_pkg::MODE_E0;
				end else if (code == ps2hid_pkg::CODE_F0) begin
					brk_plain = 1'b1;
				end else if (brk_plain) begin
					brk_plain = 1'b0;
					held = held & ~plain_mod_of(code);
				end else if (code <= ps2hid_pkg::PLAIN_LAST) begin
					held = held | plain_mod_of(code);
					r.key = PLAIN_KEY_TBL[code];
				end
			end
		endcase
		r.mods = held;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hid_report_t want;
		if (!arst_n) begin
			prefix = ps2hid_pkg::MODE_IDLE;
			brk_plain = 1'b0;
			brk_ext = 1'b0;
			pause_seen = 3'd0;
			held = 8'h00;
			errs = 0;
			awaited_reports.delete();
		end else begin
			// result first: it can never belong to a byte taken at this same edge
			if (key_valid && !key_stall) begin
				if (awaited_reports.size() == 0) begin
					$error("result item with none awaited: usb_key %02h, modifier_byte %02h",
						usb_key, modifier_byte);
					errs++;
				end else begin
					want = awaited_reports.pop_front();
					if (usb_key !== want.key) begin
						$error("usb_key: expected %02h, got %02h", want.key, usb_key);
						errs++;
					end
					if (modifier_byte !== want.mods) begin
						$error("modifier_byte: expected %02h, got %02h", want.mods,
							modifier_byte);
						errs++;
					end
				end
			end
			if (scan_valid && !scan_stall)
				awaited_reports.push_back(translate_byte(scan_code));
		end
		fail_count <= errs;
		outstanding <= awaited_reports.size();
	end

endmodule

// ===== tb/tb_top.sv =====
// top of the translator testbench: clock, reset, scan code stimulus and verdict
`timescale 1ns / 100ps

module tb_top;

	localparam int RANDOM_ITEMS   = 1050;
	localparam int DRAIN_EVERY    = 300;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int N_DIRECTED     = 26;

	// extremes, modifier make and break, break across a prefix, repeated f0,
	// e1 straight after e0, then one whole pause sequence
	localparam logic [7:0] DIRECTED_CODES [0:N_DIRECTED-1] = '{
		8'h00, 8'hff, 8'h83, 8'h14,
		8'he0, 8'h1f,
		8'hf0, 8'h14,
		8'hf0, 8'he0, 8'h75, 8'h59,
		8'he0, 8'hf0, 8'hf0, 8'h1f,
		8'he0, 8'he1,
		8'he1, 8'h14, 8'h77, 8'he1, 8'hf0, 8'h14, 8'hf0, 8'h77
	};
	localparam logic [7:0] PAUSE_TAIL [0:6] = '{
		8'h14, 8'h77, 8'he1, 8'hf0, 8'h14, 8'hf0, 8'h77
	};
	localparam logic [7:0] EXT_KEYS [0:17] = '{
		8'h11, 8'h14, 8'h1f, 8'h27, 8'h2f, 8'h4a, 8'h5a, 8'h69, 8'h6b,
		8'h6c, 8'h70, 8'h71, 8'h72, 8'h74, 8'h75, 8'h7a, 8'h7c, 8'h7d
	};
	localparam logic [7:0] PLAIN_MODS [0:3] = '{8'h11, 8'h12, 8'h14, 8'h59};

	logic       clk;
	logic       arst_n = 1'b0;
	logic       scan_valid = 1'b0;
	logic       scan_stall;
	logic [7:0] scan_code = 8'h00;
	logic       key_valid;
	logic       key_stall = 1'b0;
	logic [7:0] usb_key;
	logic [7:0] modifier_byte;

	int   fail_count;
	int   outstanding;
	int   n_sent = 0;
	int   quiet_cycles = 0;
	logic calm = 1'b0;

	ps2_scancode_to_hid_translator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.scan_valid    (scan_valid),
		.scan_stall    (scan_stall),
		.scan_code     (scan_code),
		.key_valid     (key_valid),
		.key_stall     (key_stall),
		.usb_key       (usb_key),
		.modifier_byte (modifier_byte)
	);

	hid_report_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.scan_valid    (scan_valid),
		.scan_stall    (scan_stall),
		.scan_code     (scan_code),
		.key_valid     (key_valid),
		.key_stall     (key_stall),
		.usb_key       (usb_key),
		.modifier_byte (modifier_byte),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		key_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 28);
	end

	task automatic push_code(input logic [7:0] code);
		if (!calm && $urandom_range(0, 99) < 28) begin
			scan_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		scan_valid <= 1'b1;
		scan_code <= code;
		@(posedge clk);
		while (scan_stall) @(posedge clk);
		n_sent++;
	endtask

	// hold the sender off until every report has come back
	task automatic drain_reports();
		scan_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_plain_code();
		if ($urandom_range(0, 99) < 25)
			return PLAIN_MODS[$urandom_range(0, 3)];
		return 8'($urandom_range(0, int'(ps2hid_pkg::PLAIN_LAST)));
	endfunction

	function automatic logic [7:0] pick_ext_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return EXT_KEYS[$urandom_range(0, 3)];
		if (r < 85)
			return EXT_KEYS[$urandom_range(0, 17)];
		return 8'($urandom_range(0, 255));
	endfunction

	// one keyboard event: mostly well-formed sequences, some noise bytes
	task automatic push_keystroke();
		int         kind;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		if (kind < 38) begin
			push_code(pick_plain_code());
		end else if (kind < 58) begin
			push_code(ps2hid_pkg::CODE_F0);
			push_code(pick_plain_code());
		end else if (kind < 73) begin
			push_code(ps2hid_pkg::CODE_E0);
			push_code(pick_ext_code());
		end else if (kind < 85) begin
			push_code(ps2hid_pkg::CODE_E0);
			push_code(ps2hid_pkg::CODE_F0);
			push_code(pick_ext_code());
		end else if (kind < 91) begin
			push_code(ps2hid_pkg::CODE_E1);
			for (int i = 0; i < 7; i++) begin
				b = PAUSE_TAIL[i];
				if ($urandom_range(0, 99) < 20)
					b = 8'($urandom_range(0, 255));
				push_code(b);
			end
		end else begin
			push_code(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int next_drain;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			push_code(DIRECTED_CODES[i]);
		drain_reports();

		next_drain = n_sent + DRAIN_EVERY;
		while (n_sent < N_DIRECTED + RANDOM_ITEMS) begin
			// a stretch with no random idling on either side
			calm <= (n_sent >= N_DIRECTED + 500 && n_sent < N_DIRECTED + 650);
			if (n_sent >= next_drain) begin
				drain_reports();
				next_drain += DRAIN_EVERY;
			end
			push_keystroke();
		end

		calm <= 1'b0;
		drain_reports();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((scan_valid && !scan_stall) || (key_valid && !key_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
